### rtl/gorq_pkg.sv
// Shared constants and types for the group offset retention queue.
package gorq_pkg;

  localparam int unsigned Depth       = 1024;
  localparam int unsigned Groups      = 8;
  localparam int unsigned PayloadBits = 32;

  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = IdxW + 1;
  localparam int unsigned OffW   = 32;
  localparam int unsigned GroupW = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned ActW   = 4;

  localparam logic [OffW-1:0] Sign32 = 32'h8000_0000;

  localparam logic       KindProduce = 1'b0;
  localparam logic       KindConsume = 1'b1;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef logic [OffW-1:0]     offset_t;
  typedef offset_t [Groups-1:0] offset_vec_t;

endpackage

### rtl/gorq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gorq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gorq_min.sv
// Two-stage registered minimum of the active group distances from the head.
module gorq_min (
  input  logic                  clk_i,
  input  gorq_pkg::offset_vec_t offsets_i,
  input  gorq_pkg::offset_t     head_abs_i,
  input  logic [3:0]            active_i,
  output gorq_pkg::offset_t     min_key_o
);
  import gorq_pkg::*;

  localparam int unsigned Leaves = 1 << GroupW;

  offset_t keys_q [Leaves];
  offset_t min_q;
  offset_t node   [2*Leaves];

  // Each key is the distance from the head with its sign bit flipped, so an
  // unsigned compare orders the signed distances. Inactive groups read as
  // all ones and never win.
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < Leaves; g++) begin
      if (g < Groups && g < int'(active_i)) begin
        keys_q[g] <= (offsets_i[g] - head_abs_i) ^ Sign32;
      end else begin
        keys_q[g] <= '1;
      end
    end
    min_q <= node[1];
  end

  always_comb begin
    for (int i = 0; i < 2*Leaves; i++) begin
      node[i] = '1;
    end
    for (int i = 0; i < Leaves; i++) begin
      node[Leaves+i] = keys_q[i];
    end
    for (int i = Leaves - 1; i >= 1; i--) begin
      node[i] = (node[2*i] < node[2*i+1]) ? node[2*i] : node[2*i+1];
    end
  end

  assign min_key_o = min_q;

endmodule

### rtl/group_offset_retention_queue.sv
// Top level of the ring log read by several consumer groups with their own offsets.
//
//  channel   handshake                 fields
//  -------   -----------------------   ---------------------------------------------
//  command   start, busy               kind_i, group_i, payload_i
//  result    result_valid_o (strobe)   status_o, data_o, message_offset_o,
//                                      dropped_oldest_o
//  config    cfg_we_i                  cfg_wdata_i (active groups)
//
// A produce passes the key, min and produce states, a consume the read, key, min
// and finish states; the retention minimum passes a key register and a min-tree
// register, and a consume adds the registered read of the entry RAM. The result
// strobe comes in the cycle after the last one, when busy is already low, so a new
// command may be taken in it. Reset clears pointers, head and group offsets and
// sets active groups to 3; the entry RAM stays. The receiver cannot stall results.
module group_offset_retention_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [2:0]  group_i,
  input  logic [31:0] payload_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] data_o,
  output logic [31:0] message_offset_o,
  output logic        dropped_oldest_o
);
  import gorq_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCread = 3'd1;
  localparam logic [2:0] StKey   = 3'd2;
  localparam logic [2:0] StMin   = 3'd3;
  localparam logic [2:0] StProd  = 3'd4;
  localparam logic [2:0] StCfin  = 3'd5;

  function automatic logic [IdxW-1:0] wrap_add(logic [IdxW-1:0] idx, logic [IdxW-1:0] n);
    logic [CntW-1:0] s;
    s = {1'b0, idx} + {1'b0, n};
    if (s >= CntW'(Depth)) begin
      s = s - CntW'(Depth);
    end
    return s[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] fill_of(logic [IdxW-1:0] tail, logic [IdxW-1:0] head);
    logic [CntW-1:0] s;
    if (tail >= head) begin
      s = {1'b0, tail} - {1'b0, head};
    end else begin
      s = {1'b0, tail} + CntW'(Depth) - {1'b0, head};
    end
    return s[IdxW-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  offset_t          habs_q, habs_d;
  offset_vec_t      offs_q, offs_d;
  logic [ActW-1:0]  active_q;
  logic             valid_q, valid_d;

  logic             kind_q, kind_d;
  logic [2:0]       group_q, group_d;
  logic [31:0]      payload_q, payload_d;
  logic             hit_q, hit_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      data_q, data_d;
  logic [31:0]      msg_off_q, msg_off_d;
  logic             dropped_q, dropped_d;

  logic                   ram_we, ram_re;
  logic [IdxW-1:0]        ram_waddr, ram_raddr;
  logic [PayloadBits-1:0] ram_rdata;
  offset_t                min_key;

  logic [IdxW-1:0]  count;
  logic [GroupW-1:0] gidx;
  offset_t          rel;
  offset_t          adv;
  logic             full;
  logic             drop;

  gorq_ram #(
    .Width(PayloadBits),
    .Depth(Depth)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(payload_q[PayloadBits-1:0]),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  gorq_min u_min (
    .clk_i     (clk_i),
    .offsets_i (offs_q),
    .head_abs_i(habs_q),
    .active_i  (active_q),
    .min_key_o (min_key)
  );

  assign count = fill_of(tail_q, head_q);
  assign gidx  = group_q[GroupW-1:0];
  assign rel   = offs_q[gidx] - habs_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    habs_d    = habs_q;
    offs_d    = offs_q;
    valid_d   = 1'b0;
    kind_d    = kind_q;
    group_d   = group_q;
    payload_d = payload_q;
    hit_d     = hit_q;
    status_d  = status_q;
    data_d    = data_q;
    msg_off_d = msg_off_q;
    dropped_d = dropped_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = tail_q;
    ram_raddr = wrap_add(head_q, rel[IdxW-1:0]);
    full      = (wrap_add(tail_q, IdxW'(1)) == head_q);
    drop      = full && (min_key > Sign32);
    adv       = min_key - Sign32;
    if (adv > OffW'(count)) begin
      adv = OffW'(count);
    end

    case (state_q)
      StIdle: begin
        if (start) begin
          kind_d    = kind_i;
          group_d   = group_i;
          payload_d = payload_i;
          state_d   = (kind_i == KindProduce) ? StKey : StCread;
        end
      end
      StCread: begin
        if (32'(group_q) >= Groups) begin
          status_d  = StatusEmpty;
          data_d    = '0;
          msg_off_d = '0;
          dropped_d = 1'b0;
          valid_d   = 1'b1;
          state_d   = StIdle;
        end else begin
          if (rel < OffW'(count)) begin
            ram_re       = 1'b1;
            hit_d        = 1'b1;
            msg_off_d    = offs_q[gidx];
            offs_d[gidx] = offs_q[gidx] + 32'd1;
          end else begin
            hit_d     = 1'b0;
            msg_off_d = '0;
          end
          state_d = StKey;
        end
      end
      StKey: begin
        state_d = StMin;
      end
      StMin: begin
        state_d = (kind_q == KindProduce) ? StProd : StCfin;
      end
      StProd: begin
        data_d    = '0;
        dropped_d = drop;
        if (!full || drop) begin
          ram_we    = 1'b1;
          tail_d    = wrap_add(tail_q, IdxW'(1));
          status_d  = StatusOk;
          // Dropping one entry raises the head offset by one and lowers the fill
          // by one, so the new entry's offset is the same either way.
          msg_off_d = habs_q + OffW'(count);
          if (drop) begin
            head_d = wrap_add(head_q, IdxW'(1));
            habs_d = habs_q + 32'd1;
          end
        end else begin
          status_d  = StatusFull;
          msg_off_d = '0;
        end
        valid_d = 1'b1;
        state_d = StIdle;
      end
      StCfin: begin
        status_d  = hit_q ? StatusOk : StatusEmpty;
        data_d    = hit_q ? 32'(ram_rdata) : '0;
        dropped_d = 1'b0;
        if (min_key > Sign32 && count != '0) begin
          head_d    = wrap_add(head_q, adv[IdxW-1:0]);
          habs_d    = habs_q + adv;
          dropped_d = 1'b1;
        end
        valid_d = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      head_q   <= '0;
      tail_q   <= '0;
      habs_q   <= '0;
      offs_q   <= '0;
      active_q <= 4'd3;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      habs_q  <= habs_d;
      offs_q  <= offs_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    group_q   <= group_d;
    payload_q <= payload_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
    data_q    <= data_d;
    msg_off_q <= msg_off_d;
    dropped_q <= dropped_d;
  end

  assign busy             = (state_q != StIdle);
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign data_o           = data_q;
  assign message_offset_o = msg_off_q;
  assign dropped_oldest_o = dropped_q;

endmodule

### test/gorq_checker.sv
// Checker for the group offset retention queue: predicts every result and compares it.
`timescale 1ns / 1ps
module gorq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        kind_i,
  input  logic [2:0]  group_i,
  input  logic [31:0] payload_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        result_valid_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] data_i,
  input  logic [31:0] message_offset_i,
  input  logic        dropped_oldest_i,
  output int          errors_o,
  output int          pending_o,
  output int          deliveries_o,
  output int          rejects_o,
  output int          empties_o,
  output int          drops_o
);
  import gorq_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    offset_t     offset;
    logic        dropped;
  } reply_t;

  reply_t expected_replies[$];

  // Private copy of the log state.
  logic [IdxW-1:0]        head_idx;
  logic [IdxW-1:0]        tail_idx;
  offset_t                head_off;
  offset_t                grp_off [Groups];
  logic [ActW-1:0]        act_groups;
  logic [PayloadBits-1:0] log_mem [Depth];

  // Depth is a power of two, so the modular difference is the fill level.
  function automatic logic [IdxW-1:0] ring_fill();
    return tail_idx - head_idx;
  endfunction

  // Smallest signed distance of an active group from the head, with the sign bit
  // flipped so that an unsigned compare orders it. All ones when no group is active.
  function automatic offset_t retention_key();
    int unsigned n;
    int unsigned g;
    offset_t     best;
    offset_t     key;
    n = (act_groups > Groups) ? Groups : act_groups;
    best = '1;
    for (g = 0; g < n; g++) begin
      key = (grp_off[g] - head_off) ^ Sign32;
      if (key < best) best = key;
    end
    return best;
  endfunction

  function automatic reply_t apply_command(logic kind, logic [2:0] grp, logic [31:0] word);
    reply_t          r;
    logic [IdxW-1:0] fill;
    offset_t         rel;
    offset_t         key;
    offset_t         adv;
    r = '0;
    r.status = StatusOk;
    if (kind == KindProduce) begin
      if (IdxW'(tail_idx + 1'b1) == head_idx) begin
        if (retention_key() > Sign32) begin
          head_idx = head_idx + 1'b1;
          head_off = head_off + 1;
          r.dropped = 1'b1;
        end else begin
          r.status = StatusFull;
        end
      end
      if (r.status == StatusOk) begin
        r.offset = head_off + ring_fill();
        log_mem[tail_idx] = word;
        tail_idx = tail_idx + 1'b1;
      end
    end else begin
      fill = ring_fill();
      rel = grp_off[grp] - head_off;
      if (rel < fill) begin
        r.data = log_mem[head_idx + rel[IdxW-1:0]];
        r.offset = grp_off[grp];
        grp_off[grp] = grp_off[grp] + 1;
      end else begin
        r.status = StatusEmpty;
      end
      // Retention cleanup: the head follows the slowest active group.
      key = retention_key();
      if (key > Sign32 && fill != 0) begin
        adv = key - Sign32;
        if (adv > fill) adv = fill;
        head_idx = head_idx + adv[IdxW-1:0];
        head_off = head_off + adv;
        r.dropped = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    errors_o++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t next;
    if (!rst_ni) begin
      head_idx = '0;
      tail_idx = '0;
      head_off = '0;
      for (int g = 0; g < Groups; g++) grp_off[g] = '0;
      act_groups = 4'd3;
      expected_replies.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_replies.size() == 0) begin
          flag("unexpected result, status", '0, 32'(status_i));
        end else begin
          want = expected_replies.pop_front();
          if (status_i !== want.status) flag("status", 32'(want.status), 32'(status_i));
          if (data_i !== want.data) flag("data", want.data, data_i);
          if (message_offset_i !== want.offset) begin
            flag("message_offset", want.offset, message_offset_i);
          end
          if (dropped_oldest_i !== want.dropped) begin
            flag("dropped_oldest", 32'(want.dropped), 32'(dropped_oldest_i));
          end
        end
      end
      if (cfg_we_i) act_groups = cfg_wdata_i;
      if (start_i && !busy_i) begin
        next = apply_command(kind_i, group_i, payload_i);
        expected_replies.push_back(next);
        if (next.status == StatusFull) rejects_o++;
        if (next.status == StatusEmpty) empties_o++;
        if (next.status == StatusOk && kind_i == KindConsume) deliveries_o++;
        if (next.dropped) drops_o++;
      end
    end
    pending_o = expected_replies.size();
  end

endmodule

### test/tb.sv
// Testbench top for the group offset retention queue: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
  import gorq_pkg::*;

  localparam int WatchdogLimit = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        kind_i      = KindProduce;
  logic [2:0]  group_i     = '0;
  logic [31:0] payload_i   = '0;
  logic        cfg_we_i    = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        busy;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [31:0] data_o;
  logic [31:0] message_offset_o;
  logic        dropped_oldest_o;

  int errors;
  int pending;
  int deliveries;
  int rejects;
  int empties;
  int drops;
  int burst_left   = 0;
  int items_sent   = 0;
  int idle_cycles  = 0;
  bit gaps_on      = 1'b1;

  always #4 clk_i = ~clk_i;

  group_offset_retention_queue dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .group_i          (group_i),
    .payload_i        (payload_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .data_o           (data_o),
    .message_offset_o (message_offset_o),
    .dropped_oldest_o (dropped_oldest_o)
  );

  gorq_checker retention_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .kind_i           (kind_i),
    .group_i          (group_i),
    .payload_i        (payload_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_i   (result_valid_o),
    .status_i         (status_o),
    .data_i           (data_o),
    .message_offset_i (message_offset_o),
    .dropped_oldest_i (dropped_oldest_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .deliveries_o     (deliveries),
    .rejects_o        (rejects),
    .empties_o        (empties),
    .drops_o          (drops)
  );

  // Drives one command transaction and returns at the edge that accepts it.
  task automatic issue(logic kind, logic [2:0] grp, logic [31:0] word);
    @(negedge clk_i);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(24, 1);
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(9, 1)) @(negedge clk_i);
      end
    end
    start     <= 1'b1;
    kind_i    <= kind;
    group_i   <= grp;
    payload_i <= word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Changes the active group count once every result has come back.
  task automatic write_active_groups(logic [3:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    burst_left = 0;
  endtask

  // Random traffic; hot_pct of the consumes go to the groups below hot_groups.
  task automatic random_phase(int count, int produce_pct, int hot_groups, int hot_pct);
    logic [2:0] grp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < produce_pct) begin
        issue(KindProduce, 3'($urandom), $urandom);
      end else begin
        if ($urandom_range(99) < hot_pct) grp = 3'($urandom_range(hot_groups - 1));
        else grp = 3'($urandom_range(7));
        issue(KindConsume, grp, $urandom);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("group_offset_retention_queue test failed");
      $finish;
    end
  end

  initial begin
    int g;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Three active groups after reset: empty reads, payload extremes, and the
    // head following the slowest of groups 0 to 2 while the others lag behind it.
    issue(KindConsume, 3'd0, 32'h0);
    issue(KindConsume, 3'd7, '1);
    issue(KindProduce, 3'd7, 32'h0000_0000);
    issue(KindProduce, 3'd0, 32'hFFFF_FFFF);
    issue(KindProduce, 3'd5, 32'hA5A5_5A5A);
    for (g = 0; g < 3; g++) issue(KindConsume, 3'(g), 32'h0);
    issue(KindConsume, 3'd7, 32'h0);
    for (g = 3; g < 7; g++) issue(KindConsume, 3'(g), '1);
    for (g = 0; g < 3; g++) issue(KindConsume, 3'(g), 32'h0);
    issue(KindConsume, 3'd0, 32'h0);
    issue(KindConsume, 3'd0, 32'h0);

    write_active_groups(4'd1);
    issue(KindProduce, 3'd2, 32'h8000_0001);
    issue(KindConsume, 3'd1, 32'h0);
    issue(KindConsume, 3'd0, 32'h0);

    // Groups left behind the head hold retention back, so the entries pile up.
    write_active_groups(4'd8);
    random_phase(60, 90, 1, 0);

    // Two active groups: a long run of produces fills the ring until it drops
    // and then rejects, and a few reads let the head move again.
    write_active_groups(4'd2);
    random_phase(990, 100, 2, 0);
    random_phase(20, 30, 2, 50);

    // Nothing holds back retention: a full ring drops, a consume empties it.
    write_active_groups(4'd0);
    random_phase(15, 100, 1, 0);
    random_phase(20, 60, 1, 0);

    // Above the group count; groups left behind the head now block retention.
    write_active_groups(4'd15);
    gaps_on = 1'b0;
    random_phase(25, 50, 1, 0);
    gaps_on = 1'b1;

    write_active_groups(4'd4);
    random_phase(20, 60, 4, 40);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Ran %0d transactions under active group counts 3, 1, 8, 2, 0, 15 and 4.",
             items_sent);
    $display("Delivered %0d, rejected full %0d, empty reads %0d, retention drops %0d.",
             deliveries, rejects, empties, drops);
    if (errors == 0 && pending == 0) begin
      $display("group_offset_retention_queue test passed");
    end else begin
      $display("group_offset_retention_queue test failed");
    end
    $finish;
  end

endmodule
